/* hw/rtl/idcp_pkg.sv */
// ----------------------------------------------------------------------------
// idcp_pkg
// Types and fixed constants shared by the delta colour predictor.
// ----------------------------------------------------------------------------
package idcp_pkg;

	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 4;
	localparam int WIDTH_W   = 13;
	localparam int HEIGHT_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	// chan0 sits in the low byte, matching memory order of the pixel
	typedef struct packed {
		logic [CHAN_W-1:0] chan3;
		logic [CHAN_W-1:0] chan2;
		logic [CHAN_W-1:0] chan1;
		logic [CHAN_W-1:0] chan0;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] res0;
		logic [CHAN_W-1:0] res1;
		logic [CHAN_W-1:0] res2;
		logic [CHAN_W-1:0] res3;
		logic              band_end;
		logic              image_end;
	} result_t;

	// position of a pixel in the raster, worked out when it is accepted
	typedef struct packed {
		logic first_row;
		logic row_start;
		logic band_end;
		logic image_end;
	} ctl_t;

endpackage

/* hw/rtl/idcp_line_store.sv */
// ----------------------------------------------------------------------------
// idcp_line_store
// Previous-row pixel memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module idcp_line_store #(
	parameter int MAX_WIDTH = 4096,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                access,
	input  logic [CW-1:0]       addr,
	input  idcp_pkg::pixel_t    wdata,
	output idcp_pkg::pixel_t    rdata
);

	idcp_pkg::pixel_t mem [MAX_WIDTH];
	idcp_pkg::pixel_t rdata_q;

	// read returns the old entry; the write lands for the next pixel on this column
	always_ff @(posedge clk) begin
		if (access) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/idcp_scan.sv */
// ----------------------------------------------------------------------------
// idcp_scan
// Configuration registers and raster position counters.
// ----------------------------------------------------------------------------
module idcp_scan #(
	parameter int MAX_WIDTH = 4096,
	parameter int BAND_ROWS = 4,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [idcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [idcp_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                advance,
	output logic [CW-1:0]                       col,
	output idcp_pkg::ctl_t                      ctl
);

	localparam int WW = ((CW + 1) > idcp_pkg::WIDTH_W) ? (CW + 1) : idcp_pkg::WIDTH_W;
	localparam int BW = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
	localparam logic [WW-1:0] MAXW      = WW'(MAX_WIDTH);
	localparam logic [BW-1:0] BAND_LAST = BW'(BAND_ROWS - 1);

	logic [idcp_pkg::WIDTH_W-1:0]  width_q;
	logic [idcp_pkg::HEIGHT_W-1:0] height_q;
	logic [CW-1:0]                 col_q;
	logic [idcp_pkg::HEIGHT_W-1:0] row_q;
	logic [BW-1:0]                 band_q;

	logic [WW-1:0] width_ext;
	logic [WW-1:0] eff_width;
	logic [WW-1:0] col_next;
	logic [idcp_pkg::HEIGHT_W:0] row_next;
	logic row_last;
	logic img_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= idcp_pkg::WIDTH_W'(1);
			height_q <= idcp_pkg::HEIGHT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				idcp_pkg::REG_WIDTH:  width_q  <= cfg_data[idcp_pkg::WIDTH_W-1:0];
				idcp_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero register falls out of the >= compares as one
	assign width_ext = WW'(width_q);
	assign eff_width = (width_ext > MAXW) ? MAXW : width_ext;
	assign col_next  = WW'(col_q) + WW'(1);
	assign row_next  = {1'b0, row_q} + (idcp_pkg::HEIGHT_W + 1)'(1);
	assign row_last  = (col_next >= eff_width);
	assign img_last  = row_last && (row_next >= {1'b0, height_q});

	assign col = col_q;
	always_comb begin
		ctl.first_row = (row_q == '0);
		ctl.row_start = (col_q == '0);
		ctl.band_end  = row_last && ((band_q == BAND_LAST) || img_last);
		ctl.image_end = img_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			band_q <= '0;
		end else if (advance) begin
			if (!row_last) begin
				col_q <= col_next[CW-1:0];
			end else begin
				col_q <= '0;
				if (img_last) begin
					row_q  <= '0;
					band_q <= '0;
				end else begin
					row_q  <= row_next[idcp_pkg::HEIGHT_W-1:0];
					band_q <= (band_q == BAND_LAST) ? '0 : band_q + BW'(1);
				end
			end
		end
	end

endmodule

/* hw/rtl/idcp_residual.sv */
// ----------------------------------------------------------------------------
// idcp_residual
// Vertical and horizontal deltas, green decorrelation and the output register.
// ----------------------------------------------------------------------------
module idcp_residual (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  idcp_pkg::pixel_t   pix_s1,
	input  idcp_pkg::pixel_t   above_s1,
	input  idcp_pkg::ctl_t     ctl_s1,
	input  logic               res_stall,
	output logic               ready,
	output logic               res_valid,
	output idcp_pkg::result_t  res
);

	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] cur;
	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] up;
	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] left;
	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] vdiff;
	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] resid;
	logic [idcp_pkg::NUM_CHAN-1:0][idcp_pkg::CHAN_W-1:0] left_q;

	logic              res_valid_s2;
	idcp_pkg::result_t res_s2;

	assign cur  = pix_s1;
	assign up   = ctl_s1.first_row ? '0 : above_s1;
	assign left = ctl_s1.row_start ? '0 : left_q;

	always_comb begin
		for (int c = 0; c < idcp_pkg::NUM_CHAN; c++) begin
			vdiff[c] = cur[c] - up[c];
			resid[c] = vdiff[c] - left[c];
		end
	end

	assign ready = !res_valid_s2 || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				left_q <= vdiff;
			end
			if (ready) begin
				res_valid_s2 <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2.res0      <= resid[0] - resid[1];
			res_s2.res1      <= resid[1];
			res_s2.res2      <= resid[2] - resid[1];
			res_s2.res3      <= resid[3];
			res_s2.band_end  <= ctl_s1.band_end;
			res_s2.image_end <= ctl_s1.image_end;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

/* hw/rtl/image_delta_color_predictor.sv */
// A request is registered in stage 1 and then in the output register.
// While res_stall is low, throughput is one pixel per cycle, set by the single
// line-store port pair (one read and one write of the current column every
// accepted request); a stall can hold a request in either register.
// Reset: counters, left deltas and valid flags clear; width and height go to 1.
// The line store is not cleared: each column is written on the row before it
// is read, so no clearing pass is needed and requests are taken right away.
// ----------------------------------------------------------------------------
// image_delta_color_predictor
// Two-dimensional delta predictor with green decorrelation for 4x8-bit pixels.
// ----------------------------------------------------------------------------
module image_delta_color_predictor #(
	parameter int MAX_WIDTH = 4096,
	parameter int BAND_ROWS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [idcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [idcp_pkg::CFG_W-1:0]       cfg_data,
	// pixel requests in
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  idcp_pkg::pixel_t                 pix,
	// residual requests out
	output logic                             res_valid,
	input  logic                             res_stall,
	output idcp_pkg::result_t                res
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic              accept;
	logic              s1_free;
	logic              s2_ready;
	logic              valid_s1;
	idcp_pkg::pixel_t  pix_s1;
	idcp_pkg::ctl_t    ctl_s1;
	idcp_pkg::pixel_t  above_s1;
	logic [CW-1:0]     col;
	idcp_pkg::ctl_t    scan_ctl;

	// Stage 1 frees up when it is empty or hands its request on to the output
	// register, so a waiting result blocks new requests only if stage 1 is full.
	assign s1_free   = !valid_s1 || s2_ready;
	assign pix_stall = !s1_free;
	assign accept    = pix_valid && s1_free;

	// raster position and flags of the request being accepted
	idcp_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.BAND_ROWS (BAND_ROWS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.col       (col),
		.ctl       (scan_ctl)
	);

	// Fetch the pixel above and overwrite it with the current one in the same
	// edge. A one-pixel-wide image reads back the row written by the previous
	// access, which the memory already holds, so no forwarding is needed.
	idcp_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.access (accept),
		.addr   (col),
		.wdata  (pix),
		.rdata  (above_s1)
	);

	// hold the pixel and its position next to the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			ctl_s1 <= scan_ctl;
		end
	end

	// deltas, decorrelation and the output register
	idcp_residual u_residual (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && s2_ready),
		.pix_s1    (pix_s1),
		.above_s1  (above_s1),
		.ctl_s1    (ctl_s1),
		.res_stall (res_stall),
		.ready     (s2_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// the last pixel of an image always closes a band too
	a_image_end_band: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.image_end |-> res.band_end)
		else $error("image end without band end");

	// a request held in stage 1 is neither dropped nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> valid_s1 && $stable(pix_s1) && $stable(above_s1))
		else $error("stage 1 request lost while stalled");

	// after the last pixel of an image the scan restarts at row 0, column 0
	a_image_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan_ctl.image_end |=> scan_ctl.first_row && scan_ctl.row_start)
		else $error("scan did not restart after image end");

endmodule

/* tb/sv/tb_image_delta_color_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_delta_color_predictor
// Streams pixel requests through the delta colour predictor and checks every
// residual request against an in-bench model of the raster walk, the line
// store and the green decorrelation. Covers reset-size images, zero and
// oversized registers, band and image flags, mid-image register changes and
// random images under bursty input and random output back-pressure.
// ----------------------------------------------------------------------------
module tb_image_delta_color_predictor;

	localparam int MAX_WIDTH      = 4096;
	localparam int BAND_ROWS      = 4;
	localparam int RANDOM_ITEMS   = 950;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [idcp_pkg::CFG_IDX_W-1:0] cfg_index = idcp_pkg::REG_WIDTH;
	logic [idcp_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                           pix_valid = 1'b0;
	logic                           pix_stall;
	idcp_pkg::pixel_t               pix       = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	idcp_pkg::result_t              res;

	image_delta_color_predictor #(
		.MAX_WIDTH(MAX_WIDTH),
		.BAND_ROWS(BAND_ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pixels waiting to be offered, residuals waiting to come back
	idcp_pkg::pixel_t  pixel_q[$];
	idcp_pkg::result_t residual_q[$];
	int unsigned       mismatch_count = 0;

	// mirror of the block: registers, raster position, previous row, left deltas
	logic [idcp_pkg::WIDTH_W-1:0]  width_reg  = 13'd1;
	logic [idcp_pkg::HEIGHT_W-1:0] height_reg = 16'd1;
	int unsigned                   col_pos    = 0;
	int unsigned                   row_pos    = 0;
	logic [31:0]                   left_delta = '0;
	logic [31:0]                   line_mem [MAX_WIDTH];
	bit                            line_written [MAX_WIDTH];

	// zero acts as one, anything past the line store acts as its full size
	function automatic int unsigned clamp_width(logic [idcp_pkg::WIDTH_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_WIDTH)
			return MAX_WIDTH;
		return raw;
	endfunction

	function automatic int unsigned clamp_height(logic [idcp_pkg::HEIGHT_W-1:0] raw);
		return (raw == 0) ? 1 : raw;
	endfunction

	// Residual of one accepted pixel; advances the mirrored raster position.
	function automatic idcp_pkg::result_t predict_residual(idcp_pkg::pixel_t p);
		logic [31:0]       cur, up, vdiff;
		logic [7:0]        delta [4];
		logic [7:0]        v;
		bit                row_last, image_last;
		int                k;
		idcp_pkg::result_t r;
		cur = p;
		if (col_pos == 0)
			left_delta = '0;
		up = (row_pos != 0) ? line_mem[col_pos] : '0;
		for (k = 0; k < 4; k++) begin
			v = cur[8*k +: 8] - up[8*k +: 8];
			delta[k] = v - left_delta[8*k +: 8];
			vdiff[8*k +: 8] = v;
		end
		left_delta = vdiff;
		line_mem[col_pos] = cur;
		line_written[col_pos] = 1'b1;

		// counters are compared against the registers live, so a shrink mid-row
		// ends the row (or image) as soon as the position has reached it
		row_last   = (col_pos + 1 >= clamp_width(width_reg));
		image_last = row_last && (row_pos + 1 >= clamp_height(height_reg));

		r.res0      = delta[0] - delta[1];
		r.res1      = delta[1];
		r.res2      = delta[2] - delta[1];
		r.res3      = delta[3];
		r.band_end  = row_last && ((row_pos % BAND_ROWS) == BAND_ROWS - 1 || image_last);
		r.image_end = image_last;

		if (!row_last) begin
			col_pos++;
		end else begin
			col_pos = 0;
			row_pos = image_last ? 0 : row_pos + 1;
		end
		return r;
	endfunction

	// A new width must not make the rest of this row read a column of the line
	// store that has never been written.
	function automatic bit width_safe(logic [idcp_pkg::WIDTH_W-1:0] raw);
		int unsigned last, i;
		if (row_pos == 0)
			return 1'b1;
		last = clamp_width(raw) - 1;
		if (last < col_pos)
			last = col_pos;
		for (i = col_pos; i <= last; i++)
			if (!line_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// pixels still needed to reach the end of the current image
	function automatic int unsigned pixels_left();
		int unsigned w, h, rest;
		w = clamp_width(width_reg);
		h = clamp_height(height_reg);
		rest = (col_pos + 1 >= w) ? 1 : w - col_pos;
		if (row_pos + 1 >= h)
			return rest;
		return rest + (h - 1 - row_pos) * w;
	endfunction

	// Write one register; call only while nothing is in flight.
	task automatic write_reg(input logic [idcp_pkg::CFG_IDX_W-1:0] idx,
		input logic [idcp_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == idcp_pkg::REG_WIDTH)
			width_reg = data[idcp_pkg::WIDTH_W-1:0];
		else
			height_reg = data[idcp_pkg::HEIGHT_W-1:0];
	endtask

	// Hold until every queued pixel has gone in and every residual is back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || residual_q.size() != 0 || pix_valid);
	endtask

	// Queue n pixels of one flavour: plain noise, a smooth gradient (small
	// residuals) or saturated channels.
	task automatic queue_pixels(input int unsigned n);
		int unsigned style, i, k;
		logic [31:0] base, word;
		style = $urandom_range(0, 3);
		base  = $urandom;
		@(negedge clk);
		for (i = 0; i < n; i++) begin
			case (style)
				2: begin
					for (k = 0; k < 4; k++)
						base[8*k +: 8] = base[8*k +: 8] + 8'($urandom_range(0, 4)) - 8'd2;
					word = base;
				end
				3: begin
					for (k = 0; k < 4; k++)
						case ($urandom_range(0, 2))
							0: word[8*k +: 8] = 8'h00;
							1: word[8*k +: 8] = 8'hFF;
							default: word[8*k +: 8] = 8'($urandom);
						endcase
				end
				default: word = $urandom;
			endcase
			pixel_q.push_back(idcp_pkg::pixel_t'(word));
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer pixels in bursts of random length with random gaps; hold
	// the request steady while the block stalls.
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall)
				residual_q.push_back(predict_residual(pix));
			if (!pix_valid || !pix_stall) begin
				if (gap_left != 0 || pixel_q.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					pix_valid <= 1'b0;
				end else begin
					pix_valid <= 1'b1;
					pix       <= pixel_q.pop_front();
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 47);
						gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver back-pressure: switch every so often between no stall, light
	// and heavy random stall, and a fixed one-in-three pattern.
	// ------------------------------------------------------------------------
	int unsigned stall_mode = 0;
	int unsigned stall_span = 0;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(32, 256);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= (stall_span % 3 == 0);
		endcase
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each accepted residual with the oldest prediction.
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		idcp_pkg::result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (residual_q.size() == 0) begin
				$error("residual request with no pixel outstanding");
				mismatch_count++;
			end else begin
				want = residual_q.pop_front();
				check_field("res0", want.res0, res.res0);
				check_field("res1", want.res1, res.res1);
				check_field("res2", want.res2, res.res2);
				check_field("res3", want.res3, res.res3);
				check_field("band_end", want.band_end, res.band_end);
				check_field("image_end", want.image_end, res.image_end);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: drop the run if neither channel moves for too long.
	// ------------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_image_delta_color_predictor NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: directed images first, then random phases. Registers change
	// only between phases, once the block has drained.
	// ------------------------------------------------------------------------
	logic [7:0] corner_bytes [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};

	initial begin : stimulus
		logic [idcp_pkg::WIDTH_W-1:0]  w13;
		logic [idcp_pkg::HEIGHT_W-1:0] h16;
		logic [2:0]                    pad;
		logic [31:0]                   word;
		int unsigned                   n, kind, random_sent, i, k;

		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// registers out of reset give a 1x1 image: every pixel ends a band and an image
		@(negedge clk);
		pixel_q.push_back(idcp_pkg::pixel_t'(32'h0000_0000));
		pixel_q.push_back(idcp_pkg::pixel_t'(32'hFFFF_FFFF));
		pixel_q.push_back(idcp_pkg::pixel_t'(32'h00FF_00FF));
		pixel_q.push_back(idcp_pkg::pixel_t'(32'hFF00_FF00));
		wait_drained();

		// 3x5 of corner values: first row, row starts, band end on row 3, image end
		write_reg(idcp_pkg::REG_WIDTH, 16'd3);
		write_reg(idcp_pkg::REG_HEIGHT, 16'd5);
		@(negedge clk);
		for (i = 0; i < 15; i++) begin
			for (k = 0; k < 4; k++)
				word[8*k +: 8] = corner_bytes[(i * (k + 1) + k) % 6];
			pixel_q.push_back(idcp_pkg::pixel_t'(word));
		end
		wait_drained();

		// zero registers act as one
		write_reg(idcp_pkg::REG_WIDTH, 16'd0);
		write_reg(idcp_pkg::REG_HEIGHT, 16'd0);
		@(negedge clk);
		pixel_q.push_back(idcp_pkg::pixel_t'(32'h80FF_7F00));
		pixel_q.push_back(idcp_pkg::pixel_t'(32'h017F_FE80));
		wait_drained();

		// widest value clamps to the full line store: the row runs on past
		// any narrow width without ending
		write_reg(idcp_pkg::REG_WIDTH, 16'h1FFF);
		write_reg(idcp_pkg::REG_HEIGHT, 16'd1);
		queue_pixels(256);
		wait_drained();

		// tallest image, then shrink the width mid-row so the row ends at once
		write_reg(idcp_pkg::REG_HEIGHT, 16'hFFFF);
		queue_pixels(10);
		wait_drained();
		write_reg(idcp_pkg::REG_WIDTH, 16'd6);
		queue_pixels(3);
		wait_drained();

		while (random_sent < RANDOM_ITEMS) begin
			// kind 0: change registers mid-image and send a short partial stretch
			kind = $urandom_range(0, 5);
			case ($urandom_range(0, 15))
				0: w13 = '0;
				1: w13 = 13'($urandom_range(17, 64));
				2, 3: begin
					if (kind == 0)
						w13 = ($urandom_range(0, 1) == 0) ? 13'd4096
							: 13'($urandom_range(4097, 8191));
					else
						w13 = 13'($urandom_range(1, 16));
				end
				default: w13 = 13'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 11))
				0: h16 = '0;
				1: h16 = 16'($urandom_range(11, 24));
				2, 3: begin
					if (kind == 0)
						h16 = ($urandom_range(0, 1) == 0) ? 16'hFFFF
							: 16'($urandom_range(60000, 65534));
					else
						h16 = 16'd1;
				end
				default: h16 = 16'($urandom_range(1, 9));
			endcase

			// bits above the width register are don't-care; toggle them now and then
			pad = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
			if ($urandom_range(0, 3) != 0 && width_safe(w13))
				write_reg(idcp_pkg::REG_WIDTH, {pad, w13});
			write_reg(idcp_pkg::REG_HEIGHT, h16);

			if (kind == 0) begin
				n = $urandom_range(1, 40);
			end else begin
				n = pixels_left();
				if ($urandom_range(0, 2) == 0)
					n += clamp_width(width_reg) * clamp_height(height_reg);
				if (n > 400)
					n = 400;
			end
			queue_pixels(n);
			random_sent += n;
			wait_drained();
		end

		// let any stray residual come out before the verdict
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_image_delta_color_predictor OK");
		else
			$display("tb_image_delta_color_predictor NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/idcp_pkg.sv
hw/rtl/idcp_line_store.sv
hw/rtl/idcp_scan.sv
hw/rtl/idcp_residual.sv
hw/rtl/image_delta_color_predictor.sv
tb/sv/tb_image_delta_color_predictor.sv
